/* design/event_window_trigger_assert.svh */
// Assertion macros for the event window trigger.
// Expects signals named clock and reset in the including module.
`ifndef EVENT_WINDOW_TRIGGER_ASSERT_SVH
`define EVENT_WINDOW_TRIGGER_ASSERT_SVH

// Same-cycle implication.
`define EWT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ewt assertion failed");

// Next-cycle implication.
`define EWT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ewt assertion failed");

`endif

/* design/ewt_pkg.sv */
// Shared types and constants of the event window trigger.
// No dependencies; imported by the interfaces and all modules.
package ewt_pkg;

   localparam int PIX_W   = 11;   // pixel coordinate width
   localparam int TS_W    = 48;   // timestamp width
   localparam int CTR_W   = 17;   // event and cell counter width
   localparam int FRAME_W = 12;   // frame size register width
   localparam int GRID_W  = 4;    // grid size register width
   localparam int GRID_NW = 5;    // clamped grid size, holds up to 16
   localparam int LIM_W   = 16;
   localparam int LEN_W   = 32;
   localparam int MODE_W  = 2;
   localparam int REG_IW  = 3;

   localparam logic [CTR_W-1:0] CTR_MAX = {CTR_W{1'b1}};

   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TIME  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AREA  = 2'd2;

   localparam logic ACTION_EVENT = 1'b0;
   localparam logic ACTION_START = 1'b1;

   localparam logic [REG_IW-1:0] REG_MODE         = 3'd0;
   localparam logic [REG_IW-1:0] REG_EVENT_LIMIT  = 3'd1;
   localparam logic [REG_IW-1:0] REG_REGION_LIMIT = 3'd2;
   localparam logic [REG_IW-1:0] REG_WINDOW_LEN   = 3'd3;
   localparam logic [REG_IW-1:0] REG_FRAME_WIDTH  = 3'd4;
   localparam logic [REG_IW-1:0] REG_FRAME_HEIGHT = 3'd5;
   localparam logic [REG_IW-1:0] REG_GRID_COLS    = 3'd6;
   localparam logic [REG_IW-1:0] REG_GRID_ROWS    = 3'd7;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef struct packed {
      logic rd;
      logic wr;
      logic clear;
   } cells_cmd_type;

endpackage

/* design/ewt_ifs.sv */
// Valid/ready channel interfaces for event items and trigger results.
// Depends on ewt_pkg.
interface ewt_req_if import ewt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             action;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   logic [TS_W-1:0]  timestamp_us;

   modport source (output valid, action, pixel_x, pixel_y, timestamp_us, input ready);
   modport sink (input valid, action, pixel_x, pixel_y, timestamp_us, output ready);
endinterface

interface ewt_rsp_if import ewt_pkg::*; ();
   logic valid;
   logic ready;
   logic window_ready;
   logic outside_frame;

   modport source (output valid, window_ready, outside_frame, input ready);
   modport sink (input valid, window_ready, outside_frame, output ready);
endinterface

/* design/ewt_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on ewt_pkg for the status struct.
module ewt_div import ewt_pkg::*; #(
   parameter int W = 12
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   dividend,
   input  logic [W-1:0]   divisor,
   output div_status_type status,
   output logic [W-1:0]   quotient
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     num_ff, num_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W:0]       trial;
   logic [W:0]       diff;

   assign trial = {rem_ff, num_ff[W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            num_in = {num_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            num_in = {num_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = num_ff;

endmodule

/* design/ewt_cells.sv */
// Grid cell counter store: one-port memory with per-entry valid bits.
// Depends on ewt_pkg; invalid entries read as zero, clear drops all valid bits.
module ewt_cells import ewt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  cells_cmd_type    cmd,
   input  logic [AW-1:0]    addr,
   input  logic [CTR_W-1:0] wdata,
   output logic [CTR_W-1:0] rdata
);

   logic [CTR_W-1:0] cell_mem [DEPTH];
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [CTR_W-1:0] rdata_ff;
   logic             rvalid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.wr) begin
         valid_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         cell_mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff  <= cell_mem[addr];
         rvalid_ff <= valid_ff[addr];
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

/* design/event_window_trigger.sv */
// Event window trigger top level: sequencer, registers, APB-style CSR port.
// Depends on ewt_pkg, ewt_ifs, ewt_div, ewt_cells and the assertion header.
//
// Decides, per event-camera event, whether the current accumulation window is
// complete (count, elapsed-time or grid-area rule) and returns one result
// transaction per accepted item. One item is in flight at a time. Start
// items and area events wait on one shared restoring divider of width DW =
// max(12, COORD_BITS), which produces one quotient bit per cycle. It is used
// for the two grid steps on start and for the column and row index of an
// area event. The cell counter memory adds a read state and an update state
// that writes the cell back or clears the grid. After reset the block
// computes the grid steps first and accepts no item until they are done;
// CSR writes are taken at any time. A finished result sits in an output
// register, so the next item is accepted while it waits.
`include "event_window_trigger_assert.svh"

module event_window_trigger import ewt_pkg::*; #(
   parameter int MAX_GRID_COLS = 8,
   parameter int MAX_GRID_ROWS = 8,
   parameter int COORD_BITS    = 11
) (
   input  logic              clock,
   input  logic              reset,
   ewt_req_if.sink           req,
   ewt_rsp_if.source         rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int CELL_COUNT = MAX_GRID_COLS * MAX_GRID_ROWS;
   localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int COL_W      = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
   localparam int ROW_W      = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
   localparam int DIV_W      = (COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W;
   localparam logic [DIV_W-1:0] STEP_MAX = DIV_W'((32'd1 << COORD_BITS) - 32'd1);

   // sequencer codes
   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_EVAL = 4'd2;
   localparam logic [3:0] S_DIVW = 4'd3;
   localparam logic [3:0] S_DIVH = 4'd4;
   localparam logic [3:0] S_DIVX = 4'd5;
   localparam logic [3:0] S_DIVY = 4'd6;
   localparam logic [3:0] S_READ = 4'd7;
   localparam logic [3:0] S_UPD  = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   // grid size as used: zero counts as one, large values clamp to the maximum
   function automatic logic [GRID_NW-1:0] clamp_grid(input logic [GRID_W-1:0] n,
                                                     input logic [GRID_NW-1:0] maxn);
      logic [GRID_NW-1:0] ext;
      ext = GRID_NW'(n);
      if (n == '0) begin
         return GRID_NW'(1);
      end
      return (ext > maxn) ? maxn : ext;
   endfunction

   // ---------------- configuration registers ----------------
   logic [MODE_W-1:0]  mode_ff;
   logic [LIM_W-1:0]   event_limit_ff;
   logic [LIM_W-1:0]   region_limit_ff;
   logic [LEN_W-1:0]   window_len_ff;
   logic [FRAME_W-1:0] frame_width_ff;
   logic [FRAME_W-1:0] frame_height_ff;
   logic [GRID_W-1:0]  grid_cols_ff;
   logic [GRID_W-1:0]  grid_rows_ff;

   logic               csr_wr;
   logic [REG_IW-1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_COUNT;
         event_limit_ff  <= LIM_W'(1000);
         region_limit_ff <= LIM_W'(100);
         window_len_ff   <= LEN_W'(10000);
         frame_width_ff  <= FRAME_W'(346);
         frame_height_ff <= FRAME_W'(260);
         grid_cols_ff    <= GRID_W'(4);
         grid_rows_ff    <= GRID_W'(4);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MODE:         mode_ff         <= csr_pwdata[MODE_W-1:0];
            REG_EVENT_LIMIT:  event_limit_ff  <= csr_pwdata[LIM_W-1:0];
            REG_REGION_LIMIT: region_limit_ff <= csr_pwdata[LIM_W-1:0];
            REG_WINDOW_LEN:   window_len_ff   <= csr_pwdata[LEN_W-1:0];
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[FRAME_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[FRAME_W-1:0];
            REG_GRID_COLS:    grid_cols_ff    <= csr_pwdata[GRID_W-1:0];
            REG_GRID_ROWS:    grid_rows_ff    <= csr_pwdata[GRID_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MODE:         csr_prdata = 32'(mode_ff);
         REG_EVENT_LIMIT:  csr_prdata = 32'(event_limit_ff);
         REG_REGION_LIMIT: csr_prdata = 32'(region_limit_ff);
         REG_WINDOW_LEN:   csr_prdata = window_len_ff;
         REG_FRAME_WIDTH:  csr_prdata = 32'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(frame_height_ff);
         REG_GRID_COLS:    csr_prdata = 32'(grid_cols_ff);
         REG_GRID_ROWS:    csr_prdata = 32'(grid_rows_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- datapath state ----------------
   logic [3:0]            state_ff, state_in;
   logic                  init_ff, init_in;
   logic                  action_ff, action_in;
   logic [PIX_W-1:0]      x_ff, x_in;
   logic [PIX_W-1:0]      y_ff, y_in;
   logic [TS_W-1:0]       ts_ff, ts_in;
   logic [CTR_W-1:0]      evcnt_ff, evcnt_in;
   logic [TS_W-1:0]       wstart_ff, wstart_in;
   logic [COORD_BITS-1:0] col_step_ff, col_step_in;
   logic [COORD_BITS-1:0] row_step_ff, row_step_in;
   logic [COL_W-1:0]      col_idx_ff, col_idx_in;
   logic [ROW_W-1:0]      row_idx_ff, row_idx_in;
   logic                  res_win_ff, res_win_in;
   logic                  res_out_ff, res_out_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_win_ff, rsp_win_in;
   logic                  rsp_out_ff, rsp_out_in;

   // shared divider hookup
   div_status_type        div_stat;
   logic                  div_start;
   logic [DIV_W-1:0]      div_dvd;
   logic [DIV_W-1:0]      div_dvs;
   logic [DIV_W-1:0]      div_q;
   logic [DIV_W-1:0]      step_sat;

   // cell store hookup
   cells_cmd_type         cell_cmd;
   logic [CELL_AW-1:0]    cell_addr;
   logic [CTR_W-1:0]      cell_rdata;
   logic [CTR_W-1:0]      cell_inc;

   logic [GRID_NW-1:0]    nc;
   logic [GRID_NW-1:0]    nr;
   logic [GRID_NW-1:0]    nc_m1;
   logic [GRID_NW-1:0]    nr_m1;
   logic [GRID_NW-1:0]    col_sel;
   logic [GRID_NW-1:0]    row_sel;
   logic                  outside;
   logic [TS_W-1:0]       elapsed;

   assign nc    = clamp_grid(grid_cols_ff, GRID_NW'(MAX_GRID_COLS));
   assign nr    = clamp_grid(grid_rows_ff, GRID_NW'(MAX_GRID_ROWS));
   assign nc_m1 = nc - GRID_NW'(1);
   assign nr_m1 = nr - GRID_NW'(1);

   assign outside = ({1'b0, x_ff} >= frame_width_ff) || ({1'b0, y_ff} >= frame_height_ff);
   assign elapsed = ts_ff - wstart_ff;   // wraps modulo 2^48

   // saturate a step quotient to the step register range
   assign step_sat = (div_q > STEP_MAX) ? STEP_MAX : div_q;

   // cell index: zero at the first pixel, last cell for a zero step or overrun
   always_comb begin
      if (x_ff == '0) begin
         col_sel = '0;
      end else if (col_step_ff == '0 || div_q >= DIV_W'(nc_m1)) begin
         col_sel = nc_m1;
      end else begin
         col_sel = div_q[GRID_NW-1:0];
      end
      if (y_ff == '0) begin
         row_sel = '0;
      end else if (row_step_ff == '0 || div_q >= DIV_W'(nr_m1)) begin
         row_sel = nr_m1;
      end else begin
         row_sel = div_q[GRID_NW-1:0];
      end
   end

   assign cell_addr = CELL_AW'(32'(row_idx_ff) * MAX_GRID_COLS + 32'(col_idx_ff));
   assign cell_inc  = (cell_rdata == CTR_MAX) ? cell_rdata : cell_rdata + CTR_W'(1);

   // divider operands follow the state being entered
   assign div_start = (state_in != state_ff) &&
                      (state_in == S_DIVW || state_in == S_DIVH ||
                       state_in == S_DIVX || state_in == S_DIVY);

   always_comb begin
      case (state_in)
         S_DIVW: begin
            div_dvd = DIV_W'(frame_width_ff);
            div_dvs = DIV_W'(nc);
         end
         S_DIVH: begin
            div_dvd = DIV_W'(frame_height_ff);
            div_dvs = DIV_W'(nr);
         end
         S_DIVX: begin
            div_dvd = DIV_W'(PIX_W'(x_ff - PIX_W'(1)));
            div_dvs = DIV_W'(col_step_ff);
         end
         S_DIVY: begin
            div_dvd = DIV_W'(PIX_W'(y_ff - PIX_W'(1)));
            div_dvs = DIV_W'(row_step_ff);
         end
         default: begin
            div_dvd = '0;
            div_dvs = '0;
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      action_in    = action_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ts_in        = ts_ff;
      evcnt_in     = evcnt_ff;
      wstart_in    = wstart_ff;
      col_step_in  = col_step_ff;
      row_step_in  = row_step_ff;
      col_idx_in   = col_idx_ff;
      row_idx_in   = row_idx_ff;
      res_win_in   = res_win_ff;
      res_out_in   = res_out_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_out_in   = rsp_out_ff;
      cell_cmd     = '0;

      // drop the output once taken; a new load below overrides
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            state_in = S_DIVW;
         end
         S_IDLE: begin
            if (req.valid) begin
               action_in  = req.action;
               x_in       = req.pixel_x;
               y_in       = req.pixel_y;
               ts_in      = req.timestamp_us;
               res_win_in = 1'b0;
               res_out_in = 1'b0;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            if (action_ff == ACTION_START) begin
               // new window: restart time and count, rebuild grid
               wstart_in      = ts_ff;
               evcnt_in       = '0;
               cell_cmd.clear = 1'b1;
               state_in       = S_DIVW;
            end else if (outside) begin
               res_out_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_DONE;
               case (mode_ff)
                  MODE_COUNT: begin
                     if (evcnt_ff > CTR_W'(event_limit_ff)) begin
                        res_win_in = 1'b1;
                        evcnt_in   = CTR_W'(1);
                     end else if (evcnt_ff != CTR_MAX) begin
                        evcnt_in = evcnt_ff + CTR_W'(1);
                     end
                  end
                  MODE_TIME: begin
                     if (elapsed > TS_W'(window_len_ff)) begin
                        res_win_in = 1'b1;
                        wstart_in  = ts_ff;
                     end
                  end
                  MODE_AREA: begin
                     state_in = S_DIVX;
                  end
                  default: ;   // unused mode: no effect
               endcase
            end
         end
         S_DIVW: begin
            if (div_stat.done) begin
               col_step_in = step_sat[COORD_BITS-1:0];
               state_in    = S_DIVH;
            end
         end
         S_DIVH: begin
            if (div_stat.done) begin
               row_step_in = step_sat[COORD_BITS-1:0];
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_DIVX: begin
            if (div_stat.done) begin
               col_idx_in = COL_W'(col_sel);
               state_in   = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_stat.done) begin
               row_idx_in = ROW_W'(row_sel);
               state_in   = S_READ;
            end
         end
         S_READ: begin
            cell_cmd.rd = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            // fire clears the whole grid, so the write is only needed otherwise
            if (cell_inc > CTR_W'(region_limit_ff)) begin
               res_win_in     = 1'b1;
               cell_cmd.clear = 1'b1;
            end else begin
               cell_cmd.wr = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_win_in   = res_win_ff;
               rsp_out_in   = res_out_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      ts_ff       <= ts_in;
      col_step_ff <= col_step_in;
      row_step_ff <= row_step_in;
      col_idx_ff  <= col_idx_in;
      row_idx_ff  <= row_idx_in;
      res_win_ff  <= res_win_in;
      res_out_ff  <= res_out_in;
      rsp_win_ff  <= rsp_win_in;
      rsp_out_ff  <= rsp_out_in;
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= 1'b1;
         evcnt_ff     <= '0;
         wstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         evcnt_ff     <= evcnt_in;
         wstart_ff    <= wstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.window_ready  = rsp_win_ff;
   assign rsp.outside_frame = rsp_out_ff;

   // ---------------- submodules ----------------
   ewt_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .status   (div_stat),
      .quotient (div_q)
   );

   ewt_cells #(
      .DEPTH (CELL_COUNT),
      .AW    (CELL_AW)
   ) u_cells (
      .clock (clock),
      .reset (reset),
      .cmd   (cell_cmd),
      .addr  (cell_addr),
      .wdata (cell_inc),
      .rdata (cell_rdata)
   );

   // ---------------- assertions ----------------
   `EWT_ASSERT_NXT(a_accept_leaves_idle, req.valid && req.ready, state_ff == S_EVAL)
   `EWT_ASSERT_IMP(a_idle_div_quiet, state_ff == S_IDLE, !div_stat.busy)
   `EWT_ASSERT_IMP(a_init_blocks_input, init_ff, !req.ready)
   `EWT_ASSERT_IMP(a_rsp_exclusive, rsp_valid_ff, !(rsp_win_ff && rsp_out_ff))

endmodule

/* bench/trigger_monitor.sv */
// Passive checker for the event window trigger: watches the event, result and
// CSR traffic, predicts each verdict and compares it with the returned one.
// Depends on ewt_pkg and the channel interfaces in ewt_ifs.
module trigger_monitor import ewt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ewt_req_if          req,
   ewt_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS_MAX = 8;
   localparam int ROWS_MAX = 8;
   localparam int STEP_SAT = (1 << PIX_W) - 1;

   typedef struct packed {
      logic window_ready;
      logic outside_frame;
   } trigger_verdict_type;

   // register copy
   logic [MODE_W-1:0]  mode_r;
   logic [LIM_W-1:0]   event_limit_r;
   logic [LIM_W-1:0]   region_limit_r;
   logic [LEN_W-1:0]   window_len_r;
   logic [FRAME_W-1:0] frame_w_r;
   logic [FRAME_W-1:0] frame_h_r;
   logic [GRID_W-1:0]  cols_r;
   logic [GRID_W-1:0]  rows_r;

   // window state
   logic [CTR_W-1:0]   event_count;
   logic [TS_W-1:0]    window_start;
   logic [CTR_W-1:0]   cell_count [COLS_MAX*ROWS_MAX];
   int                 col_step;
   int                 row_step;

   trigger_verdict_type pending_verdicts[$];

   function automatic int grid_span(logic [GRID_W-1:0] n, int limit);
      if (n == 0) return 1;
      return (n > limit) ? limit : int'(n);
   endfunction

   function automatic int cell_index(int p, int step, int n);
      int k;
      if (p == 0) return 0;
      if (step == 0) return n - 1;
      k = (p - 1) / step;
      return (k > n - 1) ? n - 1 : k;
   endfunction

   function automatic void load_steps();
      int c;
      int r;
      c = int'(frame_w_r) / grid_span(cols_r, COLS_MAX);
      r = int'(frame_h_r) / grid_span(rows_r, ROWS_MAX);
      col_step = (c > STEP_SAT) ? STEP_SAT : c;
      row_step = (r > STEP_SAT) ? STEP_SAT : r;
   endfunction

   function automatic void clear_cells();
      foreach (cell_count[i]) cell_count[i] = '0;
   endfunction

   // Advance the window state by one accepted item and return its verdict.
   function automatic trigger_verdict_type judge_item(logic action, logic [PIX_W-1:0] px,
         logic [PIX_W-1:0] py, logic [TS_W-1:0] ts);
      trigger_verdict_type v;
      logic [TS_W-1:0]     elapsed;
      int                  idx;
      v = '0;
      if (action == ACTION_START) begin
         window_start = ts;
         event_count  = '0;
         load_steps();
         clear_cells();
         return v;
      end
      if (px >= frame_w_r || py >= frame_h_r) begin
         v.outside_frame = 1'b1;
         return v;
      end
      case (mode_r)
         MODE_COUNT: begin
            if (event_count > event_limit_r) begin
               v.window_ready = 1'b1;
               event_count    = CTR_W'(1);
            end else if (event_count != CTR_MAX) begin
               event_count = event_count + 1'b1;
            end
         end
         MODE_TIME: begin
            elapsed = ts - window_start;
            if (elapsed > window_len_r) begin
               v.window_ready = 1'b1;
               window_start   = ts;
            end
         end
         MODE_AREA: begin
            idx = cell_index(py, row_step, grid_span(rows_r, ROWS_MAX)) * COLS_MAX
                + cell_index(px, col_step, grid_span(cols_r, COLS_MAX));
            if (cell_count[idx] != CTR_MAX) cell_count[idx] = cell_count[idx] + 1'b1;
            if (cell_count[idx] > region_limit_r) begin
               v.window_ready = 1'b1;
               clear_cells();
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      trigger_verdict_type want;
      trigger_verdict_type got;
      int                  misses;
      if (reset) begin
         mode_r         = MODE_COUNT;
         event_limit_r  = 16'd1000;
         region_limit_r = 16'd100;
         window_len_r   = 32'd10000;
         frame_w_r      = 12'd346;
         frame_h_r      = 12'd260;
         cols_r         = 4'd4;
         rows_r         = 4'd4;
         event_count    = '0;
         window_start   = '0;
         clear_cells();
         load_steps();
         pending_verdicts.delete();
         failures    <= 0;
         outstanding <= 0;
      end else begin
         misses = 0;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_MODE:         mode_r         = csr_pwdata[MODE_W-1:0];
               REG_EVENT_LIMIT:  event_limit_r  = csr_pwdata[LIM_W-1:0];
               REG_REGION_LIMIT: region_limit_r = csr_pwdata[LIM_W-1:0];
               REG_WINDOW_LEN:   window_len_r   = csr_pwdata[LEN_W-1:0];
               REG_FRAME_WIDTH:  frame_w_r      = csr_pwdata[FRAME_W-1:0];
               REG_FRAME_HEIGHT: frame_h_r      = csr_pwdata[FRAME_W-1:0];
               REG_GRID_COLS:    cols_r         = csr_pwdata[GRID_W-1:0];
               REG_GRID_ROWS:    rows_r         = csr_pwdata[GRID_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (pending_verdicts.size() == 0) begin
               $error("result transaction with no event waiting for it");
               misses++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp.window_ready !== want.window_ready) begin
                  $error("window_ready: expected %0b, actual %0b",
                         want.window_ready, rsp.window_ready);
                  misses++;
               end
               if (rsp.outside_frame !== want.outside_frame) begin
                  $error("outside_frame: expected %0b, actual %0b",
                         want.outside_frame, rsp.outside_frame);
                  misses++;
               end
            end
         end
         if (req.valid && req.ready) begin
            got = judge_item(req.action, req.pixel_x, req.pixel_y, req.timestamp_us);
            pending_verdicts.insert(pending_verdicts.size(), got);
         end
         failures    <= failures + misses;
         outstanding <= pending_verdicts.size();
      end
   end

endmodule

/* bench/tb_top.sv */
// Testbench top for the event window trigger: clock, reset, event stimulus,
// CSR programming, result back-pressure, watchdog and the verdict.
// Depends on ewt_pkg, ewt_ifs, event_window_trigger and trigger_monitor.
module tb_top import ewt_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                STALL_LIMIT  = 2000;  // cycles with no transaction at all
   localparam int                RANDOM_ITEMS = 600;
   localparam int                HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
   localparam logic [TS_W-1:0]   TS_TOP       = {TS_W{1'b1}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int outstanding;

   // calm: no idling on either side; stall_go asks the receiver for one long hold
   bit calm       = 1'b0;
   bit stall_go   = 1'b0;
   bit stall_done = 1'b0;

   // settings currently programmed, used to shape the random events
   logic [MODE_W-1:0] cfg_mode;
   int                cfg_event_limit;
   int                cfg_region_limit;
   logic [LEN_W-1:0]  cfg_window_len;
   int                cfg_frame_w;
   int                cfg_frame_h;
   int                cfg_cols;
   int                cfg_rows;

   logic [TS_W-1:0]   now_us = '0;
   int                counted = 0;
   int                phase;

   ewt_req_if req_ch();
   ewt_rsp_if rsp_ch();

   event_window_trigger dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   trigger_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #10 clock = ~clock;

   // Offer one event transaction, with random idle cycles ahead of it unless
   // calm is set, and return at the edge where it is taken. Valid stays high
   // for a following item that comes without a gap.
   task automatic send_item(logic action, int x, int y, logic [TS_W-1:0] ts);
      while (!calm && $urandom_range(0, 99) < 27) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= action;
      req_ch.pixel_x      <= PIX_W'(x);
      req_ch.pixel_y      <= PIX_W'(y);
      req_ch.timestamp_us <= ts;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and hold until every outstanding verdict has come back.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle until pready.
   task automatic write_reg(logic [REG_IW-1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_all();
      write_reg(REG_MODE,         32'(cfg_mode));
      write_reg(REG_EVENT_LIMIT,  32'(cfg_event_limit));
      write_reg(REG_REGION_LIMIT, 32'(cfg_region_limit));
      write_reg(REG_WINDOW_LEN,   cfg_window_len);
      write_reg(REG_FRAME_WIDTH,  32'(cfg_frame_w));
      write_reg(REG_FRAME_HEIGHT, 32'(cfg_frame_h));
      write_reg(REG_GRID_COLS,    32'(cfg_cols));
      write_reg(REG_GRID_ROWS,    32'(cfg_rows));
   endtask

   // Mostly small limits so windows close often, with the extremes now and then.
   function automatic int pick_limit();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 65535;
      if (roll == 1) return $urandom_range(0, 65535);
      return $urandom_range(0, 8);
   endfunction

   function automatic int pick_size();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) return 2048;
      if (roll == 2) return 1;
      return $urandom_range(1, 2048);
   endfunction

   // Grid sizes of zero and above eight get clamped by the block; hit them too.
   function automatic int pick_grid();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
      return $urandom_range(1, 8);
   endfunction

   task automatic roll_setting();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 9)     cfg_mode = MODE_UNUSED;
      else if (roll < 3) cfg_mode = MODE_COUNT;
      else if (roll < 6) cfg_mode = MODE_TIME;
      else               cfg_mode = MODE_AREA;
      cfg_event_limit  = pick_limit();
      cfg_region_limit = pick_limit();
      roll = $urandom_range(0, 19);
      if (roll == 0)      cfg_window_len = '0;
      else if (roll == 1) cfg_window_len = '1;
      else if (roll == 2) cfg_window_len = $urandom;
      else                cfg_window_len = $urandom_range(1, 400);
      cfg_frame_w = pick_size();
      cfg_frame_h = pick_size();
      cfg_cols    = pick_grid();
      cfg_rows    = pick_grid();
   endtask

   // One random transaction: mostly in-frame events with time advancing by
   // up to half a window, some starts, some out-of-frame noise and the odd
   // timestamp jump anywhere in the 48-bit range.
   task automatic random_item();
      int          pick;
      int          x;
      int          y;
      logic [63:0] span;
      pick = $urandom_range(0, 99);
      span = 64'(cfg_window_len) / 2 + 3;
      now_us = now_us + TS_W'({$urandom, $urandom} % span);
      if (pick < 4) begin
         send_item(ACTION_START, $urandom_range(0, 2047), $urandom_range(0, 2047), now_us);
         counted++;
      end else if (pick < 12) begin
         x = $urandom_range(0, 2047);
         y = $urandom_range(0, 2047);
         if (cfg_frame_w <= 2047 && (y < cfg_frame_h || $urandom_range(0, 1)))
            x = $urandom_range(cfg_frame_w, 2047);
         else if (cfg_frame_h <= 2047)
            y = $urandom_range(cfg_frame_h, 2047);
         send_item(ACTION_EVENT, x, y, now_us);
         // a full-size frame leaves nothing outside; count it as a real event then
         if (x < cfg_frame_w && y < cfg_frame_h) counted++;
      end else begin
         x = $urandom_range(0, cfg_frame_w - 1);
         y = $urandom_range(0, cfg_frame_h - 1);
         if (pick < 18) x = pick[0] ? 0 : cfg_frame_w - 1;
         else if (pick < 24) y = pick[0] ? 0 : cfg_frame_h - 1;
         if (pick >= 97) now_us = TS_W'({$urandom, $urandom});
         send_item(ACTION_EVENT, x, y, now_us);
         counted++;
      end
   endtask

   // Result side: random back-pressure, one long hold-off on request.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_go && !stall_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_done = 1'b1;
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
         end
      end
   end

   // Watchdog: end the run once nothing has moved on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_ch.valid        <= 1'b0;
      req_ch.action       <= ACTION_EVENT;
      req_ch.pixel_x      <= '0;
      req_ch.pixel_y      <= '0;
      req_ch.timestamp_us <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // hold off while the block derives its grid steps from the reset settings
      repeat (100) @(posedge clock);

      // Directed: reset settings, count mode with a limit of 1000. Frame edges,
      // out-of-frame on each axis and at the coordinate maximum, top timestamp.
      send_item(ACTION_START, 0, 0, '0);
      send_item(ACTION_EVENT, 0, 0, 48'd1);
      send_item(ACTION_EVENT, 345, 259, 48'd2);
      send_item(ACTION_EVENT, 346, 0, 48'd3);
      send_item(ACTION_EVENT, 0, 260, 48'd4);
      send_item(ACTION_EVENT, 2047, 2047, TS_TOP);
      send_item(ACTION_START, 0, 0, TS_TOP);
      settle();

      // Count limit of zero: every event after the first closes a window.
      write_reg(REG_EVENT_LIMIT, 32'd0);
      send_item(ACTION_EVENT, 1, 1, 48'd5);
      send_item(ACTION_EVENT, 2, 2, 48'd6);
      send_item(ACTION_EVENT, 3, 3, 48'd7);
      settle();

      // Time mode, zero length: equal stamp holds, one tick fires, going back wraps.
      write_reg(REG_MODE, 32'(MODE_TIME));
      write_reg(REG_WINDOW_LEN, 32'd0);
      send_item(ACTION_START, 0, 0, 48'd100);
      send_item(ACTION_EVENT, 10, 10, 48'd100);
      send_item(ACTION_EVENT, 10, 10, 48'd101);
      send_item(ACTION_EVENT, 10, 10, 48'd50);
      settle();

      // Longest window: exactly the length holds, one past it fires.
      write_reg(REG_WINDOW_LEN, 32'hFFFF_FFFF);
      send_item(ACTION_EVENT, 20, 20, 48'd50 + 48'hFFFF_FFFF);
      send_item(ACTION_EVENT, 20, 20, 48'd50 + 48'h1_0000_0000);
      settle();

      // Area mode on a 2048 x 7 frame: zero columns read as one, fifteen rows
      // as eight, the column step saturates and the row step comes out zero.
      write_reg(REG_MODE, 32'(MODE_AREA));
      write_reg(REG_REGION_LIMIT, 32'd0);
      write_reg(REG_FRAME_WIDTH, 32'd2048);
      write_reg(REG_FRAME_HEIGHT, 32'd7);
      write_reg(REG_GRID_COLS, 32'd0);
      write_reg(REG_GRID_ROWS, 32'd15);
      send_item(ACTION_START, 0, 0, 48'd200);
      send_item(ACTION_EVENT, 2047, 6, 48'd201);
      send_item(ACTION_EVENT, 0, 0, 48'd202);
      send_item(ACTION_EVENT, 1, 1, 48'd203);
      settle();

      // Unused mode: in-frame events pass without effect; an out-of-frame one is still flagged.
      write_reg(REG_MODE, 32'(MODE_UNUSED));
      send_item(ACTION_EVENT, 5, 3, 48'd204);
      send_item(ACTION_EVENT, 2047, 0, 48'd205);
      send_item(ACTION_EVENT, 0, 7, 48'd206);
      settle();

      // Random phases: reprogram while idle, open with a start most of the
      // time, then a burst of events. Phase 2 carries the long receiver
      // hold-off; phases 4 and 5 run without idling on either side.
      phase = 0;
      while (counted < RANDOM_ITEMS) begin
         roll_setting();
         program_all();
         calm = (phase == 4 || phase == 5);
         if (phase == 2) stall_go = 1'b1;
         if ($urandom_range(0, 4) != 0) begin
            send_item(ACTION_START, 0, 0, now_us);
            counted++;
         end
         repeat ($urandom_range(15, 45)) random_item();
         settle();
         phase++;
      end
      calm = 1'b0;

      // drain, then give stray results time to show up
      settle();
      repeat (80) @(posedge clock);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/ewt_pkg.sv
design/ewt_ifs.sv
design/ewt_div.sv
design/ewt_cells.sv
design/event_window_trigger.sv
bench/trigger_monitor.sv
bench/tb_top.sv
